FILE: hdl/wrsg_pkg.sv
// Shared types, constants and helpers for the waveform row span generator.
package wrsg_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned EDGE_W   = 10;
  localparam int unsigned COL_W    = 11;
  localparam int unsigned LUM_W    = 8;
  localparam int unsigned CX_W     = COL_W - 1;
  // Signed working width of scaled edges and column sums
  localparam int unsigned ACC_W    = COL_W + 1;
  localparam int unsigned PROD_W   = SAMPLE_W + COL_W;

  // Width saturation limits
  localparam int unsigned MAX_WIDTH   = 1024;
  localparam int unsigned MIN_WIDTH   = 4;
  localparam int unsigned WIDTH_LIMIT = (MAX_WIDTH > (2 ** COL_W) - 1) ?
                                        (2 ** COL_W) - 1 : MAX_WIDTH;
  localparam logic [COL_W-1:0] MAX_W_C   = COL_W'(WIDTH_LIMIT);
  localparam logic [COL_W-1:0] MIN_W_C   = COL_W'(MIN_WIDTH);
  localparam logic [COL_W-1:0] RESET_W_C = COL_W'(256);

  // Intensity scalar: (255 << 16) * 2 / w
  localparam int unsigned LUM_FULL    = 255;
  localparam int unsigned SCALE_NUM_I = LUM_FULL * 65536 * 2;
  localparam int unsigned SCALE_W     = $clog2(SCALE_NUM_I + 1);
  localparam int unsigned DIV_CNT_W   = $clog2(SCALE_W);
  localparam logic [SCALE_W-1:0] SCALE_NUM    = SCALE_W'(SCALE_NUM_I);
  localparam logic [SCALE_W-1:0] RESET_SCALAR = SCALE_W'(SCALE_NUM_I / 256);
  localparam int unsigned LUM_PROD_W  = COL_W + SCALE_W;
  localparam int unsigned LUM_SHIFT   = 16;

  // Row queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  // Sample extremes
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_RENDER_WIDTH   = 2'd0,
    CFG_SHAPE_MODE     = 2'd1,
    CFG_INTENSITY_MODE = 2'd2
  } cfg_idx_e;

  // Closed row extremes
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] row_min;
    logic signed [SAMPLE_W-1:0] row_max;
  } row_t;

  // Row queue status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Derived geometry and modes for the back end
  typedef struct packed {
    logic [CX_W-1:0]    cx;
    logic [CX_W-1:0]    wh;
    logic               shape_mode;
    logic               intensity_mode;
    logic [SCALE_W-1:0] scalar;
  } geom_t;

  // Saturate a width to the supported range
  function automatic logic [COL_W-1:0] clamp_width(input logic [COL_W-1:0] w);
    logic [COL_W-1:0] r;
    if (w < MIN_W_C) begin
      r = MIN_W_C;
    end else if (w > MAX_W_C) begin
      r = MAX_W_C;
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

FILE: hdl/wrsg_recip.sv
// Restoring divider that derives the intensity scalar from the row width.
module wrsg_recip (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [wrsg_pkg::COL_W-1:0]     divisor_i,
  output logic                           busy_o,
  output logic [wrsg_pkg::SCALE_W-1:0]   scalar_o
);

  logic                             busy_q, busy_d;
  logic [wrsg_pkg::SCALE_W-1:0]     scalar_q, scalar_d;
  logic [wrsg_pkg::SCALE_W-1:0]     quo_q, quo_d;
  logic [wrsg_pkg::COL_W-1:0]       rem_q, rem_d;
  logic [wrsg_pkg::COL_W-1:0]       div_q, div_d;
  logic [wrsg_pkg::DIV_CNT_W-1:0]   cnt_q, cnt_d;
  logic [wrsg_pkg::COL_W:0]         trial;
  logic                             fits;
  logic [wrsg_pkg::SCALE_W-1:0]     quo_next;

  // One quotient bit per cycle
  always_comb begin
    trial    = {rem_q, quo_q[wrsg_pkg::SCALE_W-1]};
    fits     = (trial >= {1'b0, div_q});
    quo_next = {quo_q[wrsg_pkg::SCALE_W-2:0], fits};
  end

  always_comb begin
    busy_d   = busy_q;
    scalar_d = scalar_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    div_d    = div_q;
    cnt_d    = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      quo_d  = wrsg_pkg::SCALE_NUM;
      rem_d  = '0;
      div_d  = divisor_i;
      cnt_d  = wrsg_pkg::DIV_CNT_W'(wrsg_pkg::SCALE_W - 1);
    end else if (busy_q) begin
      quo_d = quo_next;
      rem_d = fits ? wrsg_pkg::COL_W'(trial - {1'b0, div_q})
                   : trial[wrsg_pkg::COL_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d   = 1'b0;
        scalar_d = quo_next;
      end
    end
  end

  // Control and the scalar itself reset; the datapath does not
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      scalar_q <= wrsg_pkg::RESET_SCALAR;
    end else begin
      busy_q   <= busy_d;
      scalar_q <= scalar_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
    cnt_q <= cnt_d;
  end

  assign busy_o   = busy_q;
  assign scalar_o = scalar_q;

endmodule

FILE: hdl/wrsg_front.sv
// Front end: takes sample requests and tracks the running row extremes.
module wrsg_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [wrsg_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                sample_valid_i,
  input  logic                                row_end_i,
  input  logic                                hold_i,
  output logic                                push_o,
  output wrsg_pkg::row_t                      row_o
);

  logic signed [wrsg_pkg::SAMPLE_W-1:0] min_q, min_d;
  logic signed [wrsg_pkg::SAMPLE_W-1:0] max_q, max_d;
  logic signed [wrsg_pkg::SAMPLE_W-1:0] min_upd, max_upd;
  logic                                 accept;

  assign in_stall_o = hold_i;
  assign accept     = in_valid_i && !hold_i;

  // Fold the sample in, then close the row if asked
  always_comb begin
    min_upd = min_q;
    max_upd = max_q;
    if (sample_valid_i) begin
      if (sample_i < min_q) min_upd = sample_i;
      if (sample_i > max_q) max_upd = sample_i;
    end
    min_d = min_q;
    max_d = max_q;
    if (accept) begin
      if (row_end_i) begin
        min_d = wrsg_pkg::SAMPLE_MAX;
        max_d = wrsg_pkg::SAMPLE_MIN;
      end else begin
        min_d = min_upd;
        max_d = max_upd;
      end
    end
  end

  assign push_o      = accept && row_end_i;
  assign row_o.row_min = min_upd;
  assign row_o.row_max = max_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= wrsg_pkg::SAMPLE_MAX;
      max_q <= wrsg_pkg::SAMPLE_MIN;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

endmodule

FILE: hdl/wrsg_queue.sv
// Short queue of closed rows between the front and back ends.
module wrsg_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wrsg_pkg::row_t       push_row_i,
  input  logic                 pop_i,
  output wrsg_pkg::row_t       head_o,
  output wrsg_pkg::q_status_t  status_o
);

  wrsg_pkg::row_t                    mem_q [wrsg_pkg::QDEPTH];
  logic [wrsg_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [wrsg_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [wrsg_pkg::QPTR_W:0]         cnt_q, cnt_d;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) wr_ptr_d = wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = rd_ptr_q + 1'b1;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_row_i;
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.full  = (cnt_q == (wrsg_pkg::QPTR_W+1)'(wrsg_pkg::QDEPTH));
  assign status_o.empty = (cnt_q == '0);

endmodule

FILE: hdl/wrsg_back.sv
// Back end: scales, clamps and shapes each closed row into a span result.
module wrsg_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wrsg_pkg::row_t                      head_i,
  input  wrsg_pkg::q_status_t                 q_status_i,
  output logic                                pop_o,
  input  wrsg_pkg::geom_t                     geom_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [wrsg_pkg::EDGE_W-1:0]  edge_low_o,
  output logic signed [wrsg_pkg::EDGE_W-1:0]  edge_high_o,
  output logic [wrsg_pkg::COL_W-1:0]          span_left_o,
  output logic [wrsg_pkg::COL_W-1:0]          span_right_o,
  output logic [wrsg_pkg::LUM_W-1:0]          intensity_o
);

  localparam int unsigned ACC_W  = wrsg_pkg::ACC_W;
  localparam int unsigned PROD_W = wrsg_pkg::PROD_W;

  logic advance;
  logic v1_q, v2_q, v3_q;

  // Stage 1: products of the extremes and the half width
  logic signed [PROD_W-1:0] prod_lo_q, prod_hi_q;
  logic signed [PROD_W-1:0] prod_lo_d, prod_hi_d;
  logic signed [wrsg_pkg::COL_W-1:0] wh_s;

  // Stage 2: clamped edges, magnitude and span
  logic signed [ACC_W-1:0] lo_raw, hi_raw, lo_cl, hi_cl, lo_e, hi_e;
  logic signed [ACC_W-1:0] wh_a, cx_a, abs_lo, abs_hi, mag_a, left_a, right_a;
  logic [wrsg_pkg::COL_W-1:0] mag_d, mag_q;
  logic signed [wrsg_pkg::EDGE_W-1:0] lo2_q, hi2_q;
  logic [wrsg_pkg::COL_W-1:0] left2_q, right2_q;

  // Stage 3: intensity product and result registers
  logic [wrsg_pkg::LUM_PROD_W-1:0] lum_prod;
  logic [wrsg_pkg::LUM_W-1:0]      lum_d;
  logic signed [wrsg_pkg::EDGE_W-1:0] lo3_q, hi3_q;
  logic [wrsg_pkg::COL_W-1:0] left3_q, right3_q;
  logic [wrsg_pkg::LUM_W-1:0] lum3_q;

  // Whole pipeline moves when the result slot is free
  assign advance = !v3_q || !out_stall_i;
  assign pop_o   = advance && !q_status_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (advance) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 1 multiply, operands sign-extended to the product width
  always_comb begin
    wh_s      = $signed({1'b0, geom_i.wh});
    prod_lo_d = PROD_W'($signed(head_i.row_min)) * PROD_W'(wh_s);
    prod_hi_d = PROD_W'($signed(head_i.row_max)) * PROD_W'(wh_s);
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
    end
  end

  // Stage 2: floor shift, clamp, empty row check, span
  always_comb begin
    lo_raw = prod_lo_q[PROD_W-1 -: ACC_W];
    hi_raw = prod_hi_q[PROD_W-1 -: ACC_W];
    wh_a   = $signed({2'b00, geom_i.wh});
    cx_a   = $signed({2'b00, geom_i.cx});
    lo_cl  = (lo_raw < -wh_a) ? -wh_a : ((lo_raw > wh_a) ? wh_a : lo_raw);
    hi_cl  = (hi_raw < -wh_a) ? -wh_a : ((hi_raw > wh_a) ? wh_a : hi_raw);
    if (hi_raw >= lo_raw) begin
      lo_e = lo_cl;
      hi_e = hi_cl;
    end else begin
      lo_e = '0;
      hi_e = '0;
    end
    abs_lo = (lo_e < 0) ? -lo_e : lo_e;
    abs_hi = (hi_e < 0) ? -hi_e : hi_e;
    mag_a  = (abs_lo > abs_hi) ? abs_lo : abs_hi;
    if (geom_i.shape_mode) begin
      left_a  = cx_a + ((lo_e < 0) ? lo_e : '0);
      right_a = cx_a + ((hi_e > 0) ? hi_e : '0);
    end else begin
      left_a  = cx_a - mag_a;
      right_a = cx_a + mag_a;
    end
    mag_d = mag_a[wrsg_pkg::COL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      lo2_q    <= lo_e[wrsg_pkg::EDGE_W-1:0];
      hi2_q    <= hi_e[wrsg_pkg::EDGE_W-1:0];
      left2_q  <= left_a[wrsg_pkg::COL_W-1:0];
      right2_q <= right_a[wrsg_pkg::COL_W-1:0];
      mag_q    <= mag_d;
    end
  end

  // Stage 3: intensity
  always_comb begin
    lum_prod = wrsg_pkg::LUM_PROD_W'(mag_q) * wrsg_pkg::LUM_PROD_W'(geom_i.scalar);
    if (geom_i.intensity_mode) begin
      lum_d = lum_prod[wrsg_pkg::LUM_SHIFT +: wrsg_pkg::LUM_W];
    end else begin
      lum_d = wrsg_pkg::LUM_W'(wrsg_pkg::LUM_FULL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      lo3_q    <= lo2_q;
      hi3_q    <= hi2_q;
      left3_q  <= left2_q;
      right3_q <= right2_q;
      lum3_q   <= lum_d;
    end
  end

  assign out_valid_o  = v3_q;
  assign edge_low_o   = lo3_q;
  assign edge_high_o  = hi3_q;
  assign span_left_o  = left3_q;
  assign span_right_o = right3_q;
  assign intensity_o  = lum3_q;

endmodule

FILE: hdl/waveform_row_span_generator.sv
// Top level of the waveform row span generator: config, front, queue, back.
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+-----------------------------------
//  in      | in        | in_valid_i / in_stall_o | sample_i, sample_valid_i, row_end_i
//  out     | out       | out_valid_o/out_stall_i | edge_low_o, edge_high_o,
//          |           |                         | span_left_o, span_right_o, intensity_o
//  cfg     | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
//  One sample request per cycle while in_stall_o is low. out_valid_o rises after
//  a taken row end is written to the queue and passes the three back-end stages.
//  Writing render_width starts a restoring divider for the intensity scalar;
//  input stalls while the write is presented and while the divider is busy.
//  Reset empties the queue and pipeline, restores the register defaults and
//  the scalar for a width of 256. Output stall freezes the back end while
//  out_valid_o is high; the 4-row queue lets input run until full.
module waveform_row_span_generator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [wrsg_pkg::SAMPLE_W-1:0] sample_i,
  input  logic                                sample_valid_i,
  input  logic                                row_end_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [wrsg_pkg::EDGE_W-1:0]  edge_low_o,
  output logic signed [wrsg_pkg::EDGE_W-1:0]  edge_high_o,
  output logic [wrsg_pkg::COL_W-1:0]          span_left_o,
  output logic [wrsg_pkg::COL_W-1:0]          span_right_o,
  output logic [wrsg_pkg::LUM_W-1:0]          intensity_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [wrsg_pkg::COL_W-1:0]          cfg_data_i
);

  logic [wrsg_pkg::COL_W-1:0] render_width_q;
  logic                       shape_mode_q;
  logic                       intensity_mode_q;
  logic [wrsg_pkg::COL_W-1:0] width_eff;
  logic                       width_wr;
  logic                       div_busy;
  logic [wrsg_pkg::SCALE_W-1:0] scalar;
  wrsg_pkg::geom_t            geom;
  wrsg_pkg::q_status_t        q_status;
  wrsg_pkg::row_t             push_row, head_row;
  logic                       push, pop, hold;

  // Configuration registers
  assign width_wr = cfg_we_i &&
                    (wrsg_pkg::cfg_idx_e'(cfg_index_i) == wrsg_pkg::CFG_RENDER_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      render_width_q   <= wrsg_pkg::RESET_W_C;
      shape_mode_q     <= 1'b0;
      intensity_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (wrsg_pkg::cfg_idx_e'(cfg_index_i))
        wrsg_pkg::CFG_RENDER_WIDTH:   render_width_q   <= cfg_data_i;
        wrsg_pkg::CFG_SHAPE_MODE:     shape_mode_q     <= cfg_data_i[0];
        wrsg_pkg::CFG_INTENSITY_MODE: intensity_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Intensity scalar from the saturated width
  wrsg_recip u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (width_wr),
    .divisor_i (wrsg_pkg::clamp_width(cfg_data_i)),
    .busy_o    (div_busy),
    .scalar_o  (scalar)
  );

  // Row geometry
  always_comb begin
    width_eff           = wrsg_pkg::clamp_width(render_width_q);
    geom.cx             = width_eff[wrsg_pkg::COL_W-1:1];
    geom.wh             = width_eff[wrsg_pkg::COL_W-1:1] - 1'b1;
    geom.shape_mode     = shape_mode_q;
    geom.intensity_mode = intensity_mode_q;
    geom.scalar         = scalar;
  end

  assign hold = q_status.full || div_busy || width_wr;

  wrsg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .sample_valid_i (sample_valid_i),
    .row_end_i      (row_end_i),
    .hold_i         (hold),
    .push_o         (push),
    .row_o          (push_row)
  );

  wrsg_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_row_i (push_row),
    .pop_i      (pop),
    .head_o     (head_row),
    .status_o   (q_status)
  );

  wrsg_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_row),
    .q_status_i   (q_status),
    .pop_o        (pop),
    .geom_i       (geom),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .edge_low_o   (edge_low_o),
    .edge_high_o  (edge_high_o),
    .span_left_o  (span_left_o),
    .span_right_o (span_right_o),
    .intensity_o  (intensity_o)
  );

endmodule
